// File: hdl/pghsm_pkg.sv
// Shared types, codes and constants for the point grid height span map.
package pghsm_pkg;

	// Field widths
	localparam int OPC_W      = 2;
	localparam int HGT_W      = 16;
	localparam int CELL_X_W   = 5;
	localparam int CELL_Y_W   = 6;
	localparam int ENTRY_W    = 2 * HGT_W + 1;

	// Shifted coordinates that land inside the grid stay below this many bits
	localparam int GRID_CM_W  = 12;
	// Reciprocal scale: exact floor for GRID_CM_W-bit values and cell sizes up to 256
	localparam int DIV_SHIFT  = 20;

	// Parameter defaults
	localparam int CELL_CM_DEF        = 20;
	localparam int AREA_WIDTH_CM_DEF  = 500;
	localparam int AREA_HEIGHT_CM_DEF = 760;

	localparam logic [HGT_W-1:0] THR_RESET = 16'd10;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_ADD      = 2'd0;
	localparam logic [OPC_W-1:0] OP_READ     = 2'd1;
	localparam logic [OPC_W-1:0] OP_READ_CLR = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_IDX,
		ST_READ,
		ST_WRITE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr;
		logic capture;
		logic div;
		logic idx;
		logic rd;
		logic wb;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

// File: hdl/pghsm_ram.sv
// Generic single-port RAM with registered read.
module pghsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                              wdata,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/pghsm_ctrl.sv
// Controller state machine: clearing sweep and per-word sequencing.
module pghsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pghsm_pkg::sts_t   sts,
	output pghsm_pkg::cmd_t   cmd
);

	pghsm_pkg::state_t state_q;
	pghsm_pkg::state_t state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pghsm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Run the clearing sweep, then advance through the steps of each word
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pghsm_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = pghsm_pkg::ST_IDLE;
				end
			end
			pghsm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = pghsm_pkg::ST_DIV;
				end
			end
			pghsm_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				state_d = pghsm_pkg::ST_IDX;
			end
			pghsm_pkg::ST_IDX: begin
				cmd.idx = 1'b1;
				state_d = pghsm_pkg::ST_READ;
			end
			pghsm_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = pghsm_pkg::ST_WRITE;
			end
			pghsm_pkg::ST_WRITE: begin
				if (sts.out_free) begin
					cmd.wb  = 1'b1;
					state_d = pghsm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pghsm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/pghsm_dp.sv
// Datapath: cell lookup, cell memory update and result register.
module pghsm_dp #(
	parameter int CELL_CM        = pghsm_pkg::CELL_CM_DEF,
	parameter int AREA_WIDTH_CM  = pghsm_pkg::AREA_WIDTH_CM_DEF,
	parameter int AREA_HEIGHT_CM = pghsm_pkg::AREA_HEIGHT_CM_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pghsm_pkg::cmd_t                       cmd,
	output pghsm_pkg::sts_t                       sts,
	input  logic [pghsm_pkg::OPC_W-1:0]           opcode,
	input  logic signed [pghsm_pkg::HGT_W-1:0]    x_cm,
	input  logic signed [pghsm_pkg::HGT_W-1:0]    y_cm,
	input  logic signed [pghsm_pkg::HGT_W-1:0]    z_cm,
	input  logic [pghsm_pkg::CELL_X_W-1:0]        cell_x,
	input  logic [pghsm_pkg::CELL_Y_W-1:0]        cell_y,
	input  logic                                  cfg_valid,
	input  logic [pghsm_pkg::HGT_W-1:0]           cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  status,
	output logic [pghsm_pkg::HGT_W-1:0]           height_span,
	output logic                                  occupied
);

	localparam int GRID_COLS  = AREA_WIDTH_CM / CELL_CM;
	localparam int GRID_ROWS  = AREA_HEIGHT_CM / CELL_CM;
	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int IDX_W      = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int COL_W      = $clog2(GRID_COLS + 1);
	localparam int ROW_W      = $clog2(GRID_ROWS + 1);
	localparam int HALF_W     = AREA_WIDTH_CM / 2;
	localparam int HALF_H     = AREA_HEIGHT_CM / 2;
	localparam int SPAN_X     = GRID_COLS * CELL_CM;
	localparam int SPAN_Y     = GRID_ROWS * CELL_CM;
	localparam int SH_W       = pghsm_pkg::HGT_W + 2;
	localparam int RECIP_W    = pghsm_pkg::DIV_SHIFT + 1;
	localparam int PROD_W     = pghsm_pkg::GRID_CM_W + RECIP_W;
	localparam int RECIP      = ((1 << pghsm_pkg::DIV_SHIFT) + CELL_CM - 1) / CELL_CM;
	localparam logic [RECIP_W-1:0] RECIP_L = RECIP_W'(RECIP);
	localparam int EW         = pghsm_pkg::ENTRY_W;
	localparam int HW         = pghsm_pkg::HGT_W;

	// Captured word
	logic [pghsm_pkg::OPC_W-1:0]        op_q;
	logic signed [HW-1:0]               x_q;
	logic signed [HW-1:0]               y_q;
	logic signed [HW-1:0]               z_q;
	logic [pghsm_pkg::CELL_X_W-1:0]     cellx_q;
	logic [pghsm_pkg::CELL_Y_W-1:0]     celly_q;

	// Lookup registers
	logic [COL_W-1:0]  cx_q;
	logic [ROW_W-1:0]  cy_q;
	logic              bad_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [HW-1:0]     thr_q;

	// Result register
	logic              out_valid_q;
	logic              status_q;
	logic [HW-1:0]     span_q;
	logic              occ_q;

	logic signed [SH_W-1:0] sx;
	logic signed [SH_W-1:0] sy;
	logic                   x_in;
	logic                   y_in;
	logic                   rd_bad;
	logic [PROD_W-1:0]      prod_x;
	logic [PROD_W-1:0]      prod_y;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_addr;
	logic [EW-1:0]          ram_wdata;
	logic [EW-1:0]          ram_rdata;

	logic                   hit_rd;
	logic signed [HW-1:0]   mx_rd;
	logic signed [HW-1:0]   mn_rd;
	logic signed [HW-1:0]   mx_new;
	logic signed [HW-1:0]   mn_new;
	logic [HW-1:0]          diff;
	logic                   wb_we;
	logic [EW-1:0]          wb_data;
	logic                   res_status;
	logic [HW-1:0]          res_span;
	logic                   res_occ;

	// Capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			x_q     <= x_cm;
			y_q     <= y_cm;
			z_q     <= z_cm;
			cellx_q <= cell_x;
			celly_q <= cell_y;
		end
	end

	// Shift into grid coordinates and check the range
	assign sx     = SH_W'(x_q) + SH_W'(HALF_W);
	assign sy     = SH_W'(HALF_H) - SH_W'(y_q);
	assign x_in   = !sx[SH_W-1] && (sx < SH_W'(SPAN_X));
	assign y_in   = !sy[SH_W-1] && (sy < SH_W'(SPAN_Y));
	assign rd_bad = (32'(cellx_q) >= 32'(GRID_COLS)) || (32'(celly_q) >= 32'(GRID_ROWS));

	// Divide by the cell size through the reciprocal
	assign prod_x = PROD_W'(sx[pghsm_pkg::GRID_CM_W-1:0]) * PROD_W'(RECIP_L);
	assign prod_y = PROD_W'(sy[pghsm_pkg::GRID_CM_W-1:0]) * PROD_W'(RECIP_L);

	// Register column, row and drop flag
	always_ff @(posedge clk) begin
		if (cmd.div) begin
			if (op_q == pghsm_pkg::OP_ADD) begin
				cx_q  <= prod_x[pghsm_pkg::DIV_SHIFT +: COL_W];
				cy_q  <= prod_y[pghsm_pkg::DIV_SHIFT +: ROW_W];
				bad_q <= !(x_in && y_in);
			end else begin
				cx_q  <= COL_W'(cellx_q);
				cy_q  <= ROW_W'(celly_q);
				bad_q <= rd_bad;
			end
		end
	end

	// Form the cell index
	always_ff @(posedge clk) begin
		if (cmd.idx) begin
			idx_q <= IDX_W'(32'(cy_q) * 32'(GRID_COLS) + 32'(cx_q));
		end
	end

	// Sweep the cell memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr && !sts.clr_last) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Hold the threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pghsm_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// Unpack the stored cell
	assign hit_rd = ram_rdata[EW-1];
	assign mx_rd  = ram_rdata[2*HW-1:HW];
	assign mn_rd  = ram_rdata[HW-1:0];
	assign mx_new = (!hit_rd || (z_q > mx_rd)) ? z_q : mx_rd;
	assign mn_new = (!hit_rd || (z_q < mn_rd)) ? z_q : mn_rd;
	assign diff   = HW'(mx_rd - mn_rd);

	// Build the result and the cell update
	always_comb begin
		wb_we      = 1'b0;
		wb_data    = '0;
		res_status = 1'b0;
		res_span   = '0;
		res_occ    = 1'b0;
		case (op_q)
			pghsm_pkg::OP_ADD: begin
				res_status = bad_q;
				wb_we      = !bad_q;
				wb_data    = {1'b1, mx_new, mn_new};
			end
			pghsm_pkg::OP_READ, pghsm_pkg::OP_READ_CLR: begin
				res_status = bad_q;
				if (!bad_q && hit_rd && (diff >= thr_q)) begin
					res_occ  = 1'b1;
					res_span = diff;
				end
				wb_we = !bad_q && (op_q == pghsm_pkg::OP_READ_CLR);
			end
			default: begin
				wb_we = 1'b0;
			end
		endcase
	end

	// Cell memory port
	assign ram_we    = cmd.clr || (cmd.wb && wb_we);
	assign ram_addr  = cmd.clr ? clr_cnt_q : idx_q;
	assign ram_wdata = cmd.clr ? '0 : wb_data;

	pghsm_ram #(
		.WIDTH (EW),
		.DEPTH (GRID_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.re    (cmd.rd),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			status_q <= res_status;
			span_q   <= res_span;
			occ_q    <= res_occ;
		end
	end

	assign sts.clr_last = (clr_cnt_q == IDX_W'(GRID_CELLS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign height_span = span_q;
	assign occupied    = occ_q;

endmodule

// File: hdl/point_grid_height_span_map_core.sv
// Top level of the point grid height span map.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid in_ready opcode x_cm y_cm z_cm cell_x/y | in
//  out     | out_valid out_ready status height_span occupied  | out
//  cfg     | cfg_valid cfg_ready cfg_data (span threshold)    | in
//
// Each word runs through these steps in turn, and the next word waits for the last:
// capture, reciprocal divide, index multiply, cell memory read, cell memory write.
// The result reaches the output register in the write step. The steps run in sequence,
// with read then write on the single-port cell memory.
// After reset a clearing sweep writes every cell (GRID_CELLS, 950 at the
// default sizes) with in_ready low; configuration writes are taken.
// A stalled output word holds the next word in its final step.
module point_grid_height_span_map_core #(
	parameter int CELL_CM        = pghsm_pkg::CELL_CM_DEF,
	parameter int AREA_WIDTH_CM  = pghsm_pkg::AREA_WIDTH_CM_DEF,
	parameter int AREA_HEIGHT_CM = pghsm_pkg::AREA_HEIGHT_CM_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [pghsm_pkg::OPC_W-1:0]           opcode,
	input  logic signed [pghsm_pkg::HGT_W-1:0]    x_cm,
	input  logic signed [pghsm_pkg::HGT_W-1:0]    y_cm,
	input  logic signed [pghsm_pkg::HGT_W-1:0]    z_cm,
	input  logic [pghsm_pkg::CELL_X_W-1:0]        cell_x,
	input  logic [pghsm_pkg::CELL_Y_W-1:0]        cell_y,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pghsm_pkg::HGT_W-1:0]           cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  status,
	output logic [pghsm_pkg::HGT_W-1:0]           height_span,
	output logic                                  occupied
);

	pghsm_pkg::cmd_t cmd;
	pghsm_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	pghsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pghsm_dp #(
		.CELL_CM        (CELL_CM),
		.AREA_WIDTH_CM  (AREA_WIDTH_CM),
		.AREA_HEIGHT_CM (AREA_HEIGHT_CM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.x_cm        (x_cm),
		.y_cm        (y_cm),
		.z_cm        (z_cm),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.height_span (height_span),
		.occupied    (occupied)
	);

	// No word enters during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !in_ready)
		else $error("input ready during clearing sweep");

	// One word at a time: ready drops right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready while a word is in flight");

	// A result never overwrites a pending output word
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> (!out_valid || out_ready))
		else $error("output word overwritten");

	// A dropped point or refused read carries no span
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> ((height_span == '0) && !occupied))
		else $error("status set with nonzero span or occupied");

endmodule
